/* hw/rtl/rarl_pkg.sv */
//------------------------------------------------------------------------------
// rarl_pkg
// Shared types and constants for the ring address range lookup core.
//------------------------------------------------------------------------------
package rarl_pkg;

    localparam int unsigned MAX_ENTRIES = 256;
    localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
    localparam int unsigned SORT_STACK_DEPTH = 9;
    localparam int unsigned SP_W        = $clog2(SORT_STACK_DEPTH);
    localparam int unsigned ADDR_W      = 64;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SORT   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic CFG_LAST_STREAM = 1'b0;
    localparam logic CFG_RING_TRBS   = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OUT,
        ST_LK_RD,
        ST_LK_WAIT,
        ST_LK_CHK,
        ST_SO_POP,
        ST_SO_PV_RD,
        ST_SO_PV_WAIT,
        ST_SO_PV_GET,
        ST_SO_HI_RD,
        ST_SO_HI_WAIT,
        ST_SO_HI_CHK,
        ST_SO_LO_RD,
        ST_SO_LO_WAIT,
        ST_SO_LO_CHK,
        ST_SO_SW_HI,
        ST_SO_SW_LO,
        ST_SO_LOOP,
        ST_SO_PART
    } state_t;

    // Arithmetic right shift by 4 of (a - b)
    function automatic logic [ADDR_W-1:0] slot_dist(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic signed [ADDR_W-1:0] d;
        d = $signed(a - b);
        return ADDR_W'(d >>> 4);
    endfunction

endpackage

/* hw/rtl/rarl_ram.sv */
//------------------------------------------------------------------------------
// rarl_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
module rarl_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hw/rtl/ring_address_range_lookup_core.sv */
//------------------------------------------------------------------------------
// ring_address_range_lookup_core
// Table of ring base addresses with in-place quicksort and binary search.
//------------------------------------------------------------------------------
// Usage: s_valid/s_ready carry one command (s_mode, s_entry_index,
// s_address). Every command gives one result on m_valid/m_ready
// (m_hit, m_stream_index, m_slot_offset); non-lookups return zeros.
// Commands are handled one at a time around a single-port table RAM.
// A write stores the entry as the command is accepted and then gives its
// result. A lookup runs binary-search probes, each through RAM address,
// read wait and compare states, plus a final address state on a miss.
// A sort runs a quicksort whose length is set by the RAM reads and swap
// writes: a read and compare per scanned element, two writes per swap.
// Reset clears last_stream to 0 and ring_trbs to 256; the table is
// undefined until written. When the receiver stalls the result is held
// and no further command is accepted until it is taken.
// Configuration: cfg_we with cfg_index 0 (last_stream) or 1 (ring_trbs).
//------------------------------------------------------------------------------
module ring_address_range_lookup_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_entry_index,
    input  logic [63:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic [7:0]  m_stream_index,
    output logic [7:0]  m_slot_offset
);
    localparam int unsigned IW = rarl_pkg::IDX_W;
    localparam int unsigned SW = rarl_pkg::SP_W;
    // signed pointer width: two extra bits so hi can fall below lo
    localparam int unsigned PW = IW + 2;

    rarl_pkg::state_t state_reg, state_next;

    logic [7:0]  last_stream_reg;
    logic [8:0]  ring_trbs_reg;

    logic signed [PW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [PW-1:0] plo_reg, plo_next, phi_reg, phi_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] pv_reg, pv_next;
    logic [63:0] vhi_reg, vhi_next;
    logic        hit_reg, hit_next;
    logic [7:0]  sidx_reg, sidx_next;
    logic [7:0]  soff_reg, soff_next;
    logic [SW:0] top_reg, top_next;
    logic signed [PW-1:0] los_reg [rarl_pkg::SORT_STACK_DEPTH];
    logic signed [PW-1:0] his_reg [rarl_pkg::SORT_STACK_DEPTH];
    logic        push_en, set_en;
    logic [SW-1:0] set_at;
    logic signed [PW-1:0] set_lo, set_hi, push_lo, push_hi;

    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [63:0]   ram_wdata, ram_rdata;

    rarl_ram #(.WIDTH(64), .DEPTH(rarl_pkg::MAX_ENTRIES)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic signed [PW-1:0] last_e, mid;
    logic [63:0] dist_lk, dist_hi, dist_lo;
    logic [8:0]  lim;
    logic        hi_above, lo_above;
    logic signed [PW-1:0] p_adj, big_lo, big_hi, small_lo, small_hi;

    assign last_e = PW'(last_stream_reg);
    assign mid    = (lo_reg + hi_reg) >>> 1;
    assign lim    = (ring_trbs_reg > 9'd256) ? 9'd255 :
                    ((ring_trbs_reg >= 9'd2) ? ring_trbs_reg - 9'd1 : 9'd0);
    assign dist_lk = rarl_pkg::slot_dist(key_reg, ram_rdata);
    assign dist_hi = rarl_pkg::slot_dist(ram_rdata, pv_reg);
    assign dist_lo = rarl_pkg::slot_dist(ram_rdata, pv_reg);
    assign hi_above = !dist_hi[63] && (dist_hi != 64'd0);
    assign lo_above = !dist_lo[63] && (dist_lo != 64'd0);

    // Partition split after a pass finishes
    always_comb begin
        p_adj = (hi_reg == phi_reg) ? hi_reg - PW'(1) : hi_reg;
        if ((phi_reg - p_adj) <= (p_adj - plo_reg + PW'(1))) begin
            big_lo = plo_reg;      big_hi = p_adj;
            small_lo = p_adj + PW'(1); small_hi = phi_reg;
        end else begin
            big_lo = p_adj + PW'(1); big_hi = phi_reg;
            small_lo = plo_reg;    small_hi = p_adj;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stream_reg <= 8'd0;
            ring_trbs_reg   <= 9'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rarl_pkg::CFG_LAST_STREAM: last_stream_reg <= cfg_data[7:0];
                rarl_pkg::CFG_RING_TRBS:   ring_trbs_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and datapath
    always_comb begin
        state_next = state_reg;
        lo_next = lo_reg; hi_next = hi_reg;
        plo_next = plo_reg; phi_next = phi_reg;
        key_next = key_reg; pv_next = pv_reg; vhi_next = vhi_reg;
        hit_next = hit_reg; sidx_next = sidx_reg; soff_next = soff_reg;
        top_next = top_reg;
        push_en = 1'b0; set_en = 1'b0; set_at = '0;
        set_lo = '0; set_hi = '0; push_lo = '0; push_hi = '0;
        unique case (state_reg)
            rarl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    hit_next = 1'b0; sidx_next = 8'd0; soff_next = 8'd0;
                    key_next = s_address;
                    lo_next = PW'(1); hi_next = last_e;
                    if (s_mode == rarl_pkg::MODE_SORT) begin
                        top_next = '0;
                        set_en = 1'b1; set_lo = PW'(1); set_hi = last_e;
                        state_next = rarl_pkg::ST_SO_POP;
                    end else if (s_mode == rarl_pkg::MODE_LOOKUP) begin
                        state_next = rarl_pkg::ST_LK_RD;
                    end else begin
                        state_next = rarl_pkg::ST_OUT;
                    end
                end
            end
            rarl_pkg::ST_OUT: begin
                if (m_ready) state_next = rarl_pkg::ST_IDLE;
            end
            rarl_pkg::ST_LK_RD: begin
                state_next = (lo_reg <= hi_reg) ? rarl_pkg::ST_LK_WAIT : rarl_pkg::ST_OUT;
            end
            rarl_pkg::ST_LK_WAIT: state_next = rarl_pkg::ST_LK_CHK;
            rarl_pkg::ST_LK_CHK: begin
                state_next = rarl_pkg::ST_LK_RD;
                if (dist_lk[63]) begin
                    hi_next = mid - PW'(1);
                end else if (dist_lk >= 64'(lim)) begin
                    lo_next = mid + PW'(1);
                end else begin
                    hit_next = 1'b1;
                    sidx_next = mid[7:0];
                    soff_next = dist_lk[7:0];
                    state_next = rarl_pkg::ST_OUT;
                end
            end
            rarl_pkg::ST_SO_POP: begin
                if (top_reg[SW]) begin
                    state_next = rarl_pkg::ST_OUT;
                end else begin
                    lo_next = los_reg[top_reg[SW-1:0]];
                    hi_next = his_reg[top_reg[SW-1:0]];
                    plo_next = los_reg[top_reg[SW-1:0]];
                    phi_next = his_reg[top_reg[SW-1:0]];
                    if (los_reg[top_reg[SW-1:0]] >= his_reg[top_reg[SW-1:0]]) begin
                        top_next = top_reg - 1'b1;
                    end else begin
                        state_next = rarl_pkg::ST_SO_PV_RD;
                    end
                end
            end
            rarl_pkg::ST_SO_PV_RD:   state_next = rarl_pkg::ST_SO_PV_WAIT;
            rarl_pkg::ST_SO_PV_WAIT: state_next = rarl_pkg::ST_SO_PV_GET;
            rarl_pkg::ST_SO_PV_GET: begin
                pv_next = ram_rdata;
                state_next = rarl_pkg::ST_SO_HI_RD;
            end
            rarl_pkg::ST_SO_HI_RD: begin
                state_next = (lo_reg <= hi_reg) ? rarl_pkg::ST_SO_HI_WAIT
                                                : rarl_pkg::ST_SO_LO_RD;
            end
            rarl_pkg::ST_SO_HI_WAIT: state_next = rarl_pkg::ST_SO_HI_CHK;
            rarl_pkg::ST_SO_HI_CHK: begin
                if (hi_above) begin
                    hi_next = hi_reg - PW'(1);
                    state_next = rarl_pkg::ST_SO_HI_RD;
                end else begin
                    vhi_next = ram_rdata;
                    state_next = rarl_pkg::ST_SO_LO_RD;
                end
            end
            rarl_pkg::ST_SO_LO_RD: begin
                state_next = (lo_reg <= hi_reg) ? rarl_pkg::ST_SO_LO_WAIT
                                                : rarl_pkg::ST_SO_LOOP;
            end
            rarl_pkg::ST_SO_LO_WAIT: state_next = rarl_pkg::ST_SO_LO_CHK;
            rarl_pkg::ST_SO_LO_CHK: begin
                if (!lo_above) begin
                    lo_next = lo_reg + PW'(1);
                    state_next = rarl_pkg::ST_SO_LO_RD;
                end else begin
                    key_next = ram_rdata;
                    state_next = (lo_reg < hi_reg) ? rarl_pkg::ST_SO_SW_HI
                                                   : rarl_pkg::ST_SO_LOOP;
                end
            end
            rarl_pkg::ST_SO_SW_HI: state_next = rarl_pkg::ST_SO_SW_LO;
            rarl_pkg::ST_SO_SW_LO: begin
                lo_next = lo_reg + PW'(1);
                hi_next = hi_reg - PW'(1);
                state_next = rarl_pkg::ST_SO_LOOP;
            end
            rarl_pkg::ST_SO_LOOP: begin
                state_next = (lo_reg <= hi_reg) ? rarl_pkg::ST_SO_HI_RD
                                                : rarl_pkg::ST_SO_PART;
            end
            rarl_pkg::ST_SO_PART: begin
                set_en = 1'b1; set_at = top_reg[SW-1:0];
                set_lo = big_lo; set_hi = big_hi;
                if (32'(top_reg) + 1 < rarl_pkg::SORT_STACK_DEPTH) begin
                    push_en = 1'b1; push_lo = small_lo; push_hi = small_hi;
                    top_next = top_reg + 1'b1;
                end
                state_next = rarl_pkg::ST_SO_POP;
            end
            default: state_next = rarl_pkg::ST_IDLE;
        endcase
    end

    // RAM port control; hold the read address through the wait cycle
    always_comb begin
        ram_we = 1'b0; ram_addr = '0; ram_wdata = key_reg;
        unique case (state_reg)
            rarl_pkg::ST_IDLE: begin
                ram_addr = s_entry_index[IW-1:0];
                ram_wdata = s_address;
                ram_we = s_valid && (s_mode == rarl_pkg::MODE_WRITE);
            end
            rarl_pkg::ST_LK_RD:      ram_addr = mid[IW-1:0];
            rarl_pkg::ST_LK_WAIT:    ram_addr = mid[IW-1:0];
            rarl_pkg::ST_SO_PV_RD:   ram_addr = hi_reg[IW-1:0];
            rarl_pkg::ST_SO_PV_WAIT: ram_addr = hi_reg[IW-1:0];
            rarl_pkg::ST_SO_HI_RD:   ram_addr = hi_reg[IW-1:0];
            rarl_pkg::ST_SO_HI_WAIT: ram_addr = hi_reg[IW-1:0];
            rarl_pkg::ST_SO_LO_RD:   ram_addr = lo_reg[IW-1:0];
            rarl_pkg::ST_SO_LO_WAIT: ram_addr = lo_reg[IW-1:0];
            rarl_pkg::ST_SO_SW_HI: begin
                ram_we = 1'b1; ram_addr = hi_reg[IW-1:0]; ram_wdata = key_reg;
            end
            rarl_pkg::ST_SO_SW_LO: begin
                ram_we = 1'b1; ram_addr = lo_reg[IW-1:0]; ram_wdata = vhi_reg;
            end
            default: ;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready = (state_reg == rarl_pkg::ST_IDLE);
        m_valid = (state_reg == rarl_pkg::ST_OUT);
        m_hit = hit_reg;
        m_stream_index = sidx_reg;
        m_slot_offset = soff_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rarl_pkg::ST_IDLE;
            top_reg   <= '0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
        end
    end

    // Payload registers and sort stack
    always_ff @(posedge aclk) begin
        lo_reg <= lo_next; hi_reg <= hi_next;
        plo_reg <= plo_next; phi_reg <= phi_next;
        key_reg <= key_next; pv_reg <= pv_next; vhi_reg <= vhi_next;
        hit_reg <= hit_next; sidx_reg <= sidx_next; soff_reg <= soff_next;
        if (set_en) begin
            los_reg[set_at] <= set_lo;
            his_reg[set_at] <= set_hi;
        end
        if (push_en) begin
            los_reg[SW'(top_reg + 1'b1)] <= push_lo;
            his_reg[SW'(top_reg + 1'b1)] <= push_hi;
        end
    end
endmodule
